@@ src/shac_pkg.sv @@
// SHA-512 compression package: types, FSM states, round constants, rotate function.
// No dependencies.
`default_nettype none
package shac_pkg;

  localparam int unsigned WordW  = 64;
  localparam int unsigned Rounds = 80;
  localparam int unsigned Window = 16;
  localparam int unsigned RoundW = 7;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_MSG  = 1'b1
  } opcode_e;

  typedef struct packed {
    logic        opcode;
    logic [2:0]  word_index;
    logic [63:0] data_word;
  } in_item_t;

  typedef struct packed {
    logic [63:0] hash_word;
    logic [2:0]  out_index;
    logic        last;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FOLD,
    ST_EMIT
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic       init;    // copy chaining words into working vars
    logic       round;   // perform one round
    logic       fold;    // add working vars into chaining words
    logic       emit;    // present a result
    logic [6:0] rnd;     // round number
    logic [2:0] oidx;    // output index
  } ctrl_t;

  function automatic logic [63:0] k_const(input logic [6:0] t);
    logic [63:0] k;
    unique case (t)
      7'd0: k = 64'h428a2f98d728ae22;  7'd1: k = 64'h7137449123ef65cd;
      7'd2: k = 64'hb5c0fbcfec4d3b2f;  7'd3: k = 64'he9b5dba58189dbbc;
      7'd4: k = 64'h3956c25bf348b538;  7'd5: k = 64'h59f111f1b605d019;
      7'd6: k = 64'h923f82a4af194f9b;  7'd7: k = 64'hab1c5ed5da6d8118;
      7'd8: k = 64'hd807aa98a3030242;  7'd9: k = 64'h12835b0145706fbe;
      7'd10: k = 64'h243185be4ee4b28c; 7'd11: k = 64'h550c7dc3d5ffb4e2;
      7'd12: k = 64'h72be5d74f27b896f; 7'd13: k = 64'h80deb1fe3b1696b1;
      7'd14: k = 64'h9bdc06a725c71235; 7'd15: k = 64'hc19bf174cf692694;
      7'd16: k = 64'he49b69c19ef14ad2; 7'd17: k = 64'hefbe4786384f25e3;
      7'd18: k = 64'h0fc19dc68b8cd5b5; 7'd19: k = 64'h240ca1cc77ac9c65;
      7'd20: k = 64'h2de92c6f592b0275; 7'd21: k = 64'h4a7484aa6ea6e483;
      7'd22: k = 64'h5cb0a9dcbd41fbd4; 7'd23: k = 64'h76f988da831153b5;
      7'd24: k = 64'h983e5152ee66dfab; 7'd25: k = 64'ha831c66d2db43210;
      7'd26: k = 64'hb00327c898fb213f; 7'd27: k = 64'hbf597fc7beef0ee4;
      7'd28: k = 64'hc6e00bf33da88fc2; 7'd29: k = 64'hd5a79147930aa725;
      7'd30: k = 64'h06ca6351e003826f; 7'd31: k = 64'h142929670a0e6e70;
      7'd32: k = 64'h27b70a8546d22ffc; 7'd33: k = 64'h2e1b21385c26c926;
      7'd34: k = 64'h4d2c6dfc5ac42aed; 7'd35: k = 64'h53380d139d95b3df;
      7'd36: k = 64'h650a73548baf63de; 7'd37: k = 64'h766a0abb3c77b2a8;
      7'd38: k = 64'h81c2c92e47edaee6; 7'd39: k = 64'h92722c851482353b;
      7'd40: k = 64'ha2bfe8a14cf10364; 7'd41: k = 64'ha81a664bbc423001;
      7'd42: k = 64'hc24b8b70d0f89791; 7'd43: k = 64'hc76c51a30654be30;
      7'd44: k = 64'hd192e819d6ef5218; 7'd45: k = 64'hd69906245565a910;
      7'd46: k = 64'hf40e35855771202a; 7'd47: k = 64'h106aa07032bbd1b8;
      7'd48: k = 64'h19a4c116b8d2d0c8; 7'd49: k = 64'h1e376c085141ab53;
      7'd50: k = 64'h2748774cdf8eeb99; 7'd51: k = 64'h34b0bcb5e19b48a8;
      7'd52: k = 64'h391c0cb3c5c95a63; 7'd53: k = 64'h4ed8aa4ae3418acb;
      7'd54: k = 64'h5b9cca4f7763e373; 7'd55: k = 64'h682e6ff3d6b2b8a3;
      7'd56: k = 64'h748f82ee5defb2fc; 7'd57: k = 64'h78a5636f43172f60;
      7'd58: k = 64'h84c87814a1f0ab72; 7'd59: k = 64'h8cc702081a6439ec;
      7'd60: k = 64'h90befffa23631e28; 7'd61: k = 64'ha4506cebde82bde9;
      7'd62: k = 64'hbef9a3f7b2c67915; 7'd63: k = 64'hc67178f2e372532b;
      7'd64: k = 64'hca273eceea26619c; 7'd65: k = 64'hd186b8c721c0c207;
      7'd66: k = 64'heada7dd6cde0eb1e; 7'd67: k = 64'hf57d4f7fee6ed178;
      7'd68: k = 64'h06f067aa72176fba; 7'd69: k = 64'h0a637dc5a2c898a6;
      7'd70: k = 64'h113f9804bef90dae; 7'd71: k = 64'h1b710b35131c471b;
      7'd72: k = 64'h28db77f523047d84; 7'd73: k = 64'h32caab7b40c72493;
      7'd74: k = 64'h3c9ebe0a15c9bebc; 7'd75: k = 64'h431d67c49c100d4c;
      7'd76: k = 64'h4cc5d4becb3e42b6; 7'd77: k = 64'h597f299cfc657e2a;
      7'd78: k = 64'h5fcb6fab3ad6faec; 7'd79: k = 64'h6c44198c4a475817;
      default: k = '0;
    endcase
    return k;
  endfunction

  function automatic logic [63:0] ror(input logic [63:0] v, input int unsigned n);
    return (v >> n) | (v << (64 - n));
  endfunction

endpackage
`default_nettype wire

@@ src/shac_ctrl.sv @@
// SHA-512 compression controller: sequences rounds, fold and result emission.
// Depends on shac_pkg.
`default_nettype none
module shac_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          go_i,     // sixteenth message word accepted
  output shac_pkg::ctrl_t    ctrl_o,
  output logic               busy_o
);
  import shac_pkg::*;

  state_e     state_q, state_d;
  logic [6:0] cnt_q, cnt_d;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (go_i) state_d = ST_ROUND;
      end
      ST_ROUND: begin
        if (cnt_q == 7'(Rounds - 1)) begin
          state_d = ST_FOLD;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + 7'd1;
        end
      end
      ST_FOLD: begin
        state_d = ST_EMIT;
        cnt_d   = '0;
      end
      ST_EMIT: begin
        if (cnt_q == 7'd7) state_d = ST_IDLE;
        cnt_d = cnt_q + 7'd1;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o       = '0;
    ctrl_o.init  = (state_q == ST_IDLE) && go_i;
    ctrl_o.round = (state_q == ST_ROUND);
    ctrl_o.fold  = (state_q == ST_FOLD);
    ctrl_o.emit  = (state_q == ST_EMIT);
    ctrl_o.rnd   = cnt_q;
    ctrl_o.oidx  = cnt_q[2:0];
    busy_o       = (state_q != ST_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule
`default_nettype wire

@@ src/shac_dp.sv @@
// SHA-512 compression datapath: chaining words, schedule window, round unit.
// Depends on shac_pkg.
`default_nettype none
module shac_dp (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              acc_i,   // input transaction accepted
  input  shac_pkg::in_item_t     item_i,
  input  shac_pkg::ctrl_t        ctrl_i,
  output logic                   go_o,
  output shac_pkg::out_item_t    res_o,
  output logic                   strobe_o
);
  import shac_pkg::*;

  logic [63:0] chain_q [8];
  logic [63:0] w_q [16];
  logic [63:0] v_q [8];
  logic [3:0]  mcnt_q;

  logic [63:0] w_new, s0, s1, t1, t2, big0, big1, ch, maj, wt;

  assign go_o = acc_i && (item_i.opcode == OP_MSG) && (mcnt_q == 4'd15);

  // schedule: w_q[0] is W[t]; shift window each round
  assign wt    = w_q[0];
  assign s0    = ror(w_q[1], 1) ^ ror(w_q[1], 8) ^ (w_q[1] >> 7);
  assign s1    = ror(w_q[14], 19) ^ ror(w_q[14], 61) ^ (w_q[14] >> 6);
  assign w_new = w_q[0] + s0 + w_q[9] + s1;

  assign big1 = ror(v_q[4], 14) ^ ror(v_q[4], 18) ^ ror(v_q[4], 41);
  assign ch   = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
  assign t1   = v_q[7] + big1 + ch + k_const(ctrl_i.rnd) + wt;
  assign big0 = ror(v_q[0], 28) ^ ror(v_q[0], 34) ^ ror(v_q[0], 39);
  assign maj  = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
  assign t2   = big0 + maj;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mcnt_q <= '0;
      for (int i = 0; i < 8; i++) chain_q[i] <= '0;
    end else begin
      if (acc_i && item_i.opcode == OP_MSG) mcnt_q <= mcnt_q + 4'd1;
      if (acc_i && item_i.opcode == OP_LOAD) chain_q[item_i.word_index] <= item_i.data_word;
      if (ctrl_i.fold) begin
        for (int i = 0; i < 8; i++) chain_q[i] <= chain_q[i] + v_q[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_i && item_i.opcode == OP_MSG) w_q[mcnt_q] <= item_i.data_word;
    if (ctrl_i.round) begin
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= w_new;
    end
    if (ctrl_i.init) begin
      for (int i = 0; i < 8; i++) v_q[i] <= chain_q[i];
    end else if (ctrl_i.round) begin
      v_q[7] <= v_q[6];
      v_q[6] <= v_q[5];
      v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2];
      v_q[2] <= v_q[1];
      v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
    end
  end

  assign strobe_o        = ctrl_i.emit;
  assign res_o.hash_word = chain_q[ctrl_i.oidx];
  assign res_o.out_index = ctrl_i.oidx;
  assign res_o.last      = ctrl_i.emit && (ctrl_i.oidx == 3'd7);

endmodule
`default_nettype wire

@@ src/sha512_block_compress.sv @@
// SHA-512 block compression top level: controller plus datapath.
// Depends on shac_pkg, shac_ctrl, shac_dp.
//
// Usage:
//  - Input channel: drive item_i and pulse start_i; a transaction is taken
//    on a rising edge with start_i high and busy_o low.
//  - Load transactions (opcode 0) write a chaining word; message
//    transactions (opcode 1) fill the 16-word schedule window.
//  - Load and non-final message words produce no result.
//  - The sixteenth message word starts a run: 80 rounds (one round
//    per cycle in the shared round unit), a fold of the working
//    variables into the chaining words, then eight results. busy_o
//    stays high for the run; the results appear on consecutive cycles,
//    each marked by result_valid_o, the last with last set.
//  - No transaction is taken while a run is in progress (busy_o high).
//  - The receiver cannot stall; each result is valid for one cycle only.
//  - Reset clears the chaining words and the message count; the schedule
//    window and working variables need no reset.
`default_nettype none
module sha512_block_compress (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  shac_pkg::in_item_t     item_i,
  output logic                   busy_o,
  output logic                   result_valid_o,
  output shac_pkg::out_item_t    result_o
);
  import shac_pkg::*;

  ctrl_t ctrl;
  logic  go;
  logic  acc;

  assign acc = start_i && !busy_o;

  shac_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (go),
    .ctrl_o (ctrl),
    .busy_o (busy_o)
  );

  shac_dp u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .acc_i    (acc),
    .item_i   (item_i),
    .ctrl_i   (ctrl),
    .go_o     (go),
    .res_o    (result_o),
    .strobe_o (result_valid_o)
  );

endmodule
`default_nettype wire

@@ src/shac_checker.sv @@
// Port-level checker for sha512_block_compress, bound to the top level.
// Depends on shac_pkg.
`default_nettype none
module shac_checker (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             start_i,
  input wire logic             busy_o,
  input wire logic             result_valid_o,
  input shac_pkg::out_item_t   result_o
);
  a_res_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy_o) else $error("result outside busy");
  a_idx_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !result_o.last) |=> (result_valid_o &&
      result_o.out_index == $past(result_o.out_index) + 3'd1))
    else $error("result sequence broken");
  a_last_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.last) |=> !busy_o) else $error("busy after last");
  a_last_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.last) |-> result_o.out_index == 3'd7)
    else $error("last on wrong index");
  a_acc_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> !result_valid_o) else $error("result during accept");
endmodule

bind sha512_block_compress shac_checker u_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .result_valid_o (result_valid_o),
  .result_o       (result_o)
);
`default_nettype wire
